>>> rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg: shared types and codes of the searchable stack engine
// Command and result item layouts, operation and status codes, FSM states.
// ----------------------------------------------------------------------------
package sse_pkg;

  // operation codes carried in cmd_t.mode
  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_LIST   = 3'd1;
  localparam logic [2:0] MODE_SEARCH = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;
  localparam logic [2:0] MODE_MODIFY = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [4:0]         position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic [4:0]         item_position;
    logic [4:0]         removed_count;
    logic [4:0]         depth_now;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST,
    S_SCAN,
    S_MOD,
    S_EMIT
  } state_t;

endpackage

>>> rtl/searchable_stack_engine_unit.sv
// ----------------------------------------------------------------------------
// searchable_stack_engine_unit: bounded LIFO stack with search and delete
// Push, list, search, delete-matching, clear and modify-by-position on a
// stack held in one synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
//
//  channel | signals                      | direction | moves
//  --------+------------------------------+-----------+------------------------
//  command | cmd_valid, cmd_ready, cmd    | in        | one operation item
//  result  | res_valid, res_ready, res    | out       | one or more result items
//
//  Flow: push, clear and any early-out (empty, full, bad position) go straight
//  to emit; modify reads the old entry, writes the new one, then emits. List
//  starts with a read of the top entry and gives one result per cycle while
//  the result side is not stalled. Search and delete scan the RAM one entry
//  per cycle, set by the single RAM read port. One item is in work at a time.
//  Reset: synchronous, clears entry_count and the control state only; RAM
//  contents stay undefined until written, and only live entries are read.
//  Stalls: a held result blocks the next result but not the next command
//  acceptance; the engine waits at its emit point while res_valid is held.
// ----------------------------------------------------------------------------
module searchable_stack_engine_unit #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sse_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output sse_pkg::res_t res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  // squeeze a count into the 5-bit result fields
  function automatic logic [4:0] to5(input logic [CW-1:0] x);
    logic [CW+4:0] t;
    t = {5'b0, x};
    return t[4:0];
  endfunction

  // stack storage
  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rd_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [VW-1:0] wr_data;

  // control registers
  sse_pkg::state_t state, state_next;
  logic [CW-1:0]   entry_count, entry_count_next;
  logic [VW-1:0]   key, key_next;
  logic            op_del, op_del_next;
  logic [AW-1:0]   mod_idx, mod_idx_next;
  logic [4:0]      mod_pos, mod_pos_next;
  logic [AW-1:0]   list_idx, list_idx_next;
  logic [CW-1:0]   list_pos, list_pos_next;
  logic [CW-1:0]   scan_rd, scan_rd_next;
  logic            rd_vld, rd_vld_next;
  logic            rd_last, rd_last_next;
  logic            found, found_next;
  logic [CW-1:0]   keep, keep_next;
  sse_pkg::res_t   pend, pend_next;
  logic            res_valid_next;
  sse_pkg::res_t   res_next;

  // value conversions between the 32-bit item fields and stored width
  logic [VW+31:0] key_ext, rd_ext;
  logic [VW-1:0]  cmd_key;
  logic [31:0]    rd_val32;
  assign key_ext  = {{VW{1'b0}}, cmd.value};
  assign cmd_key  = key_ext[VW-1:0];
  assign rd_ext   = {32'b0, rd_data};
  assign rd_val32 = rd_ext[31:0];

  // modify position check and address
  logic [CW+4:0] pos_x, cnt_x, idx_x;
  assign pos_x = {{CW{1'b0}}, cmd.position};
  assign cnt_x = {5'b0, entry_count};
  assign idx_x = cnt_x - pos_x;

  logic [CW-1:0] cnt_m1;
  assign cnt_m1 = entry_count - CW'(1);

  logic out_free;
  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == sse_pkg::S_IDLE);

  logic scan_issue, match;
  assign scan_issue = (scan_rd < entry_count);
  assign match      = rd_vld && (rd_data == key);

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    key_next         = key;
    op_del_next      = op_del;
    mod_idx_next     = mod_idx;
    mod_pos_next     = mod_pos;
    list_idx_next    = list_idx;
    list_pos_next    = list_pos;
    scan_rd_next     = scan_rd;
    rd_vld_next      = 1'b0;
    rd_last_next     = 1'b0;
    found_next       = found;
    keep_next        = keep;
    pend_next        = pend;
    res_valid_next   = res_valid && !res_ready;
    res_next         = res;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = '0;

    unique case (state)
      sse_pkg::S_IDLE: begin
        if (cmd_valid) begin
          key_next  = cmd_key;
          pend_next = '0;
          if (cmd.mode == sse_pkg::MODE_PUSH) begin
            // push never needs a read: write on top right away
            if (entry_count >= CW'(DEPTH)) begin
              pend_next.status = sse_pkg::ST_FULL;
            end else begin
              wr_en            = 1'b1;
              wr_addr          = entry_count[AW-1:0];
              wr_data          = cmd_key;
              entry_count_next = entry_count + CW'(1);
              pend_next.status = sse_pkg::ST_OK;
            end
            state_next = sse_pkg::S_EMIT;
          end else if (cmd.mode <= sse_pkg::MODE_MODIFY) begin
            if (entry_count == '0) begin
              pend_next.status = sse_pkg::ST_EMPTY;
              state_next       = sse_pkg::S_EMIT;
            end else begin
              unique case (cmd.mode)
                sse_pkg::MODE_LIST: begin
                  // start with the top entry
                  rd_en         = 1'b1;
                  rd_addr       = cnt_m1[AW-1:0];
                  list_idx_next = cnt_m1[AW-1:0];
                  list_pos_next = CW'(1);
                  state_next    = sse_pkg::S_LIST;
                end
                sse_pkg::MODE_SEARCH, sse_pkg::MODE_DELETE: begin
                  op_del_next  = (cmd.mode == sse_pkg::MODE_DELETE);
                  scan_rd_next = '0;
                  found_next   = 1'b0;
                  keep_next    = '0;
                  state_next   = sse_pkg::S_SCAN;
                end
                sse_pkg::MODE_CLEAR: begin
                  pend_next.status        = sse_pkg::ST_OK;
                  pend_next.removed_count = to5(entry_count);
                  entry_count_next        = '0;
                  state_next              = sse_pkg::S_EMIT;
                end
                default: begin
                  // modify
                  if (pos_x == '0 || pos_x > cnt_x) begin
                    pend_next.status = sse_pkg::ST_NOTFOUND;
                    state_next       = sse_pkg::S_EMIT;
                  end else begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_x[AW-1:0];
                    mod_idx_next = idx_x[AW-1:0];
                    mod_pos_next = cmd.position;
                    state_next   = sse_pkg::S_MOD;
                  end
                end
              endcase
            end
          end
          // unused mode codes: drop the item, no result
        end
      end

      sse_pkg::S_LIST: begin
        // rd_data holds the entry at list_idx until the next read
        if (out_free) begin
          res_valid_next         = 1'b1;
          res_next.status        = sse_pkg::ST_OK;
          res_next.item_value    = rd_val32;
          res_next.item_position = to5(list_pos);
          res_next.removed_count = '0;
          res_next.depth_now     = to5(entry_count);
          res_next.last          = (list_pos == entry_count);
          if (list_pos == entry_count) begin
            state_next = sse_pkg::S_IDLE;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = list_idx - AW'(1);
            list_idx_next = list_idx - AW'(1);
            list_pos_next = list_pos + CW'(1);
          end
        end
      end

      sse_pkg::S_SCAN: begin
        // issue one read per cycle, compare the entry read last cycle
        if (scan_issue) begin
          rd_en        = 1'b1;
          rd_addr      = scan_rd[AW-1:0];
          scan_rd_next = scan_rd + CW'(1);
        end
        rd_vld_next  = scan_issue;
        rd_last_next = scan_issue && (scan_rd == cnt_m1);
        found_next   = found || match;
        // compact survivors downward; keep never passes the read pointer
        if (op_del && rd_vld && !match) begin
          wr_en     = 1'b1;
          wr_addr   = keep[AW-1:0];
          wr_data   = rd_data;
          keep_next = keep + CW'(1);
        end
        if (rd_vld && rd_last) begin
          pend_next = '0;
          if (op_del) begin
            entry_count_next        = keep_next;
            pend_next.removed_count = to5(entry_count - keep_next);
            pend_next.status        = (entry_count != keep_next) ? sse_pkg::ST_OK
                                                                 : sse_pkg::ST_NOTFOUND;
          end else begin
            pend_next.status = found_next ? sse_pkg::ST_OK : sse_pkg::ST_NOTFOUND;
          end
          state_next = sse_pkg::S_EMIT;
        end
      end

      sse_pkg::S_MOD: begin
        // rd_data is the old entry; overwrite it with the new value
        wr_en                   = 1'b1;
        wr_addr                 = mod_idx;
        wr_data                 = key;
        pend_next               = '0;
        pend_next.status        = sse_pkg::ST_OK;
        pend_next.item_value    = rd_val32;
        pend_next.item_position = mod_pos;
        state_next              = sse_pkg::S_EMIT;
      end

      sse_pkg::S_EMIT: begin
        // hold until the result register frees up
        if (out_free) begin
          res_valid_next     = 1'b1;
          res_next           = pend;
          res_next.depth_now = to5(entry_count);
          res_next.last      = 1'b1;
          state_next         = sse_pkg::S_IDLE;
        end
      end

      default: state_next = sse_pkg::S_IDLE;
    endcase
  end

  // stack RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sse_pkg::S_IDLE;
      entry_count <= '0;
      res_valid   <= 1'b0;
      rd_vld      <= 1'b0;
      rd_last     <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      res_valid   <= res_valid_next;
      rd_vld      <= rd_vld_next;
      rd_last     <= rd_last_next;
    end
  end

  always_ff @(posedge clk) begin
    key      <= key_next;
    op_del   <= op_del_next;
    mod_idx  <= mod_idx_next;
    mod_pos  <= mod_pos_next;
    list_idx <= list_idx_next;
    list_pos <= list_pos_next;
    scan_rd  <= scan_rd_next;
    found    <= found_next;
    keep     <= keep_next;
    pend     <= pend_next;
    res      <= res_next;
  end

endmodule

>>> rtl/sse_checker.sv
// ----------------------------------------------------------------------------
// sse_checker: port-level checks of the searchable stack engine
// Watches both channels and flags result and acceptance slips.
// ----------------------------------------------------------------------------
module sse_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input sse_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_ready,
  input sse_pkg::res_t res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // one operation at a time: a real command closes the command side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd.mode <= sse_pkg::MODE_MODIFY) |=> !cmd_ready)
    else $error("command accepted while another is in work");

  // an empty-stack result reports zero depth and ends its item
  a_empty_depth: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == sse_pkg::ST_EMPTY) |-> (res.depth_now == '0) && res.last)
    else $error("empty status with entries or without last");

  // any failure is a single result with no position
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != sse_pkg::ST_OK) |-> res.last && (res.item_position == '0))
    else $error("failure result not final or carries a position");

endmodule

bind searchable_stack_engine_unit sse_checker u_sse_checker (.*);
